// ----- sv/clock_display_mode_controller_assert.svh -----
// Assertion macros for the clock display mode controller; assume clk and rst_n in scope.
`ifndef CLOCK_DISPLAY_MODE_CONTROLLER_ASSERT_SVH
`define CLOCK_DISPLAY_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CDMC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("cdmc same-cycle check failed");

// next-cycle implication
`define CDMC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("cdmc next-cycle check failed");

`endif

// ----- sv/cdmc_pkg.sv -----
// Types, constants and digit helpers shared by the clock display mode controller.
`timescale 1ns / 1ps

package cdmc_pkg;

  localparam int NOW_W   = 32;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int TEMP_W  = 9;
  localparam int SEG_W   = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // blink phase: bit 0 of now / 250 = bit 0 of (now >> 1) / 125, exact for 31-bit input
  localparam logic [31:0] BLINK_MAGIC = 32'd2199023256;
  localparam int          BLINK_SHIFT = 38;

  localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
  localparam logic [6:0] MINS_PER_HOUR   = 7'd60;
  localparam logic [HOUR_W-1:0] EDIT_HOURS_RESET = 5'd12;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_C     = 8'h39;

  localparam logic [SEG_W-1:0] SEG_TAB [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  localparam logic [CFG_W-1:0] CYCLE_LENGTH_RESET = 16'd50000;
  localparam logic [CFG_W-1:0] TEMP_SHOW_RESET    = 16'd45000;
  localparam logic [CFG_W-1:0] SHORT_MIN_RESET    = 16'd50;
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RESET  = 16'd1500;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SHOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd4;

  typedef enum logic [1:0] {
    MODE_CLOCK = 2'd0,
    MODE_SET_H = 2'd1,
    MODE_SET_M = 2'd2,
    MODE_TEMP  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] cycle_length_ms;
    logic [CFG_W-1:0] temp_show_from_ms;
    logic [CFG_W-1:0] short_press_min_ms;
    logic [CFG_W-1:0] short_press_limit_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]         now_ms;
    logic                     button_down;
    logic [HOUR_W-1:0]        clock_hours;
    logic [MIN_W-1:0]         clock_minutes;
    logic                     colon_on;
    logic signed [TEMP_W-1:0] temperature_c;
    logic                     lit;
  } item_t;

  typedef struct packed {
    logic [SEG_W-1:0]  seg_digit3;
    logic [SEG_W-1:0]  seg_digit2;
    logic [SEG_W-1:0]  seg_digit1;
    logic [SEG_W-1:0]  seg_digit0;
    logic [1:0]        mode_now;
    logic              time_write;
    logic [HOUR_W-1:0] write_hours;
    logic [MIN_W-1:0]  write_minutes;
  } result_t;

  // x / 10, exact for x < 1029
  function automatic logic [9:0] div10(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd205;
    return p[20:11];
  endfunction

  // x / 100, exact for x <= 256
  function automatic logic [9:0] div100(input logic [9:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd41;
    return 10'(p[15:12]);
  endfunction

  function automatic logic [SEG_W-1:0] seg7(input logic [9:0] x);
    logic [13:0] r;
    r = 14'(x) - 14'(div10(x)) * 14'd10;
    return SEG_TAB[r[3:0]];
  endfunction

endpackage

// ----- sv/cdmc_if.sv -----
// Valid/ready channel interfaces for input samples and display results.
`timescale 1ns / 1ps

interface cdmc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [cdmc_pkg::NOW_W-1:0]             now_ms;
  logic                                   button_down;
  logic [cdmc_pkg::HOUR_W-1:0]            clock_hours;
  logic [cdmc_pkg::MIN_W-1:0]             clock_minutes;
  logic                                   colon_on;
  logic signed [cdmc_pkg::TEMP_W-1:0]     temperature_c;

  modport source (output valid, now_ms, button_down, clock_hours, clock_minutes,
                  colon_on, temperature_c, input ready);
  modport sink   (input valid, now_ms, button_down, clock_hours, clock_minutes,
                  colon_on, temperature_c, output ready);
endinterface

interface cdmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [cdmc_pkg::SEG_W-1:0]   seg_digit3;
  logic [cdmc_pkg::SEG_W-1:0]   seg_digit2;
  logic [cdmc_pkg::SEG_W-1:0]   seg_digit1;
  logic [cdmc_pkg::SEG_W-1:0]   seg_digit0;
  logic [1:0]                   mode_now;
  logic                         time_write;
  logic [cdmc_pkg::HOUR_W-1:0]  write_hours;
  logic [cdmc_pkg::MIN_W-1:0]   write_minutes;

  modport source (output valid, seg_digit3, seg_digit2, seg_digit1, seg_digit0,
                  mode_now, time_write, write_hours, write_minutes, input ready);
  modport sink   (input valid, seg_digit3, seg_digit2, seg_digit1, seg_digit0,
                  mode_now, time_write, write_hours, write_minutes, output ready);
endinterface

// ----- sv/cdmc_cfg.sv -----
// Configuration register file for press thresholds and display cycle timing.
`timescale 1ns / 1ps

module cdmc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cdmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdmc_pkg::CFG_W-1:0]       cfg_wdata,
  output cdmc_pkg::cfg_t                   cfg
);

  cdmc_pkg::cfg_t cfg_r;
  cdmc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cdmc_pkg::CFG_CYCLE_LENGTH: cfg_nxt.cycle_length_ms      = cfg_wdata;
        cdmc_pkg::CFG_TEMP_SHOW:    cfg_nxt.temp_show_from_ms    = cfg_wdata;
        cdmc_pkg::CFG_SHORT_MIN:    cfg_nxt.short_press_min_ms   = cfg_wdata;
        cdmc_pkg::CFG_SHORT_LIMIT:  cfg_nxt.short_press_limit_ms = cfg_wdata;
        cdmc_pkg::CFG_LONG_PRESS:   cfg_nxt.long_press_ms        = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_length_ms      <= cdmc_pkg::CYCLE_LENGTH_RESET;
      cfg_r.temp_show_from_ms    <= cdmc_pkg::TEMP_SHOW_RESET;
      cfg_r.short_press_min_ms   <= cdmc_pkg::SHORT_MIN_RESET;
      cfg_r.short_press_limit_ms <= cdmc_pkg::SHORT_LIMIT_RESET;
      cfg_r.long_press_ms        <= cdmc_pkg::LONG_PRESS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/cdmc_in_stage.sv -----
// Input register: captures a sample and its precomputed blink phase.
`timescale 1ns / 1ps

module cdmc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  cdmc_in_if.sink           in_ch,
  input  logic              adv,
  output logic              s1_valid,
  output cdmc_pkg::item_t   s1_item
);

  logic              valid_r;
  logic              valid_nxt;
  cdmc_pkg::item_t   item_r;
  cdmc_pkg::item_t   item_nxt;
  logic [62:0]       blink_prod;
  logic              xfer;

  assign in_ch.ready = !valid_r || adv;
  assign xfer        = in_ch.valid && in_ch.ready;

  // product carries floor(now / 250) from bit BLINK_SHIFT up
  assign blink_prod = 63'(in_ch.now_ms[cdmc_pkg::NOW_W-1:1]) * 63'(cdmc_pkg::BLINK_MAGIC);

  always_comb begin
    item_nxt.now_ms        = in_ch.now_ms;
    item_nxt.button_down   = in_ch.button_down;
    item_nxt.clock_hours   = in_ch.clock_hours;
    item_nxt.clock_minutes = in_ch.clock_minutes;
    item_nxt.colon_on      = in_ch.colon_on;
    item_nxt.temperature_c = in_ch.temperature_c;
    item_nxt.lit           = !blink_prod[cdmc_pkg::BLINK_SHIFT];
    if (xfer) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- sv/cdmc_step.sv -----
// Button timing, mode sequencing, display cycle and segment encoding for one sample.
`timescale 1ns / 1ps

module cdmc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cdmc_pkg::item_t   it,
  input  cdmc_pkg::cfg_t    cfg,
  output cdmc_pkg::result_t res
);

  cdmc_pkg::mode_t                   mode_r, mode_nxt;
  logic [cdmc_pkg::NOW_W-1:0]        cycle_start_r, cycle_start_nxt;
  logic [cdmc_pkg::NOW_W-1:0]        press_start_r, press_start_nxt;
  logic                              press_seen_r, press_seen_nxt;
  logic [cdmc_pkg::HOUR_W-1:0]       edit_hours_r, edit_hours_nxt;
  logic [cdmc_pkg::MIN_W-1:0]        edit_minutes_r, edit_minutes_nxt;
  logic signed [cdmc_pkg::TEMP_W-1:0] held_temp_r, held_temp_nxt;
  logic                              snapshot_done_r, snapshot_done_nxt;

  logic [cdmc_pkg::NOW_W-1:0]        dur;
  logic [cdmc_pkg::NOW_W-1:0]        elapsed;
  logic [5:0]                        hour_sum;
  logic [6:0]                        min_sum;
  logic [cdmc_pkg::HOUR_W-1:0]       hour_inc;
  logic [cdmc_pkg::MIN_W-1:0]        min_inc;
  logic                              wr;
  logic [cdmc_pkg::HOUR_W-1:0]       show_h;
  logic [cdmc_pkg::MIN_W-1:0]        show_m;
  logic [9:0]                        temp_ext;
  logic [9:0]                        mag;
  logic [cdmc_pkg::SEG_W-1:0]        cmask;
  logic [cdmc_pkg::SEG_W-1:0]        h1, h0, m1, m0;
  logic [cdmc_pkg::SEG_W-1:0]        d3, d2, d1, d0;

  assign dur      = it.now_ms - press_start_r;
  assign hour_sum = 6'(edit_hours_r) + 6'd1;
  assign min_sum  = 7'(edit_minutes_r) + 7'd1;
  assign hour_inc = (hour_sum >= cdmc_pkg::HOURS_PER_DAY) ?
                    5'(hour_sum - cdmc_pkg::HOURS_PER_DAY) : 5'(hour_sum);
  assign min_inc  = (min_sum >= cdmc_pkg::MINS_PER_HOUR) ?
                    6'(min_sum - cdmc_pkg::MINS_PER_HOUR) : 6'(min_sum);

  always_comb begin
    mode_nxt          = mode_r;
    cycle_start_nxt   = cycle_start_r;
    press_start_nxt   = press_start_r;
    press_seen_nxt    = press_seen_r;
    edit_hours_nxt    = edit_hours_r;
    edit_minutes_nxt  = edit_minutes_r;
    held_temp_nxt     = held_temp_r;
    snapshot_done_nxt = snapshot_done_r;
    wr                = 1'b0;
    show_h            = it.clock_hours;
    show_m            = it.clock_minutes;

    if (it.button_down && !press_seen_r) begin
      press_start_nxt = it.now_ms;
      press_seen_nxt  = 1'b1;
    end else if (!it.button_down && press_seen_r) begin
      press_seen_nxt = 1'b0;
      if (dur >= 32'(cfg.short_press_min_ms) && dur < 32'(cfg.short_press_limit_ms)) begin
        if (mode_r == cdmc_pkg::MODE_SET_H) begin
          edit_hours_nxt = hour_inc;
        end else if (mode_r == cdmc_pkg::MODE_SET_M) begin
          edit_minutes_nxt = min_inc;
        end
      end
    end else if (it.button_down && press_seen_r && dur >= 32'(cfg.long_press_ms)) begin
      press_seen_nxt = 1'b0;
      case (mode_r)
        cdmc_pkg::MODE_CLOCK: begin
          edit_hours_nxt   = it.clock_hours;
          edit_minutes_nxt = it.clock_minutes;
          mode_nxt         = cdmc_pkg::MODE_SET_H;
        end
        cdmc_pkg::MODE_SET_H: begin
          mode_nxt = cdmc_pkg::MODE_SET_M;
        end
        cdmc_pkg::MODE_SET_M: begin
          wr              = 1'b1;
          show_h          = edit_hours_r;
          show_m          = edit_minutes_r;
          mode_nxt        = cdmc_pkg::MODE_CLOCK;
          cycle_start_nxt = it.now_ms;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    elapsed = it.now_ms - cycle_start_nxt;
    if (mode_nxt == cdmc_pkg::MODE_CLOCK || mode_nxt == cdmc_pkg::MODE_TEMP) begin
      if (elapsed >= 32'(cfg.cycle_length_ms)) begin
        cycle_start_nxt = it.now_ms;
        mode_nxt        = cdmc_pkg::MODE_CLOCK;
      end else if (elapsed >= 32'(cfg.temp_show_from_ms)) begin
        mode_nxt = cdmc_pkg::MODE_TEMP;
      end else begin
        mode_nxt = cdmc_pkg::MODE_CLOCK;
      end
    end

    if (mode_nxt == cdmc_pkg::MODE_CLOCK) begin
      snapshot_done_nxt = 1'b0;
    end else if (mode_nxt == cdmc_pkg::MODE_TEMP && !snapshot_done_r) begin
      held_temp_nxt     = it.temperature_c;
      snapshot_done_nxt = 1'b1;
    end

    // temperature magnitude, sign handled separately
    temp_ext = {held_temp_nxt[cdmc_pkg::TEMP_W-1], held_temp_nxt};
    mag      = held_temp_nxt[cdmc_pkg::TEMP_W-1] ? (10'd0 - temp_ext) : temp_ext;

    cmask = it.colon_on ? cdmc_pkg::SEG_DP : cdmc_pkg::SEG_BLANK;
    h1 = cdmc_pkg::seg7(cdmc_pkg::div10(10'(edit_hours_nxt)))   | cdmc_pkg::SEG_DP;
    h0 = cdmc_pkg::seg7(10'(edit_hours_nxt))                    | cdmc_pkg::SEG_DP;
    m1 = cdmc_pkg::seg7(cdmc_pkg::div10(10'(edit_minutes_nxt))) | cdmc_pkg::SEG_DP;
    m0 = cdmc_pkg::seg7(10'(edit_minutes_nxt))                  | cdmc_pkg::SEG_DP;

    case (mode_nxt)
      cdmc_pkg::MODE_CLOCK: begin
        d3 = cdmc_pkg::seg7(cdmc_pkg::div10(10'(show_h))) | cmask;
        d2 = cdmc_pkg::seg7(10'(show_h))                  | cmask;
        d1 = cdmc_pkg::seg7(cdmc_pkg::div10(10'(show_m))) | cmask;
        d0 = cdmc_pkg::seg7(10'(show_m))                  | cmask;
      end
      cdmc_pkg::MODE_TEMP: begin
        d0 = cdmc_pkg::SEG_C;
        d1 = cdmc_pkg::seg7(mag);
        d2 = (mag >= 10'd10) ? cdmc_pkg::seg7(cdmc_pkg::div10(mag)) : cdmc_pkg::SEG_BLANK;
        if (held_temp_nxt[cdmc_pkg::TEMP_W-1]) begin
          d3 = cdmc_pkg::SEG_MINUS;
        end else if (mag >= 10'd100) begin
          d3 = cdmc_pkg::seg7(cdmc_pkg::div100(mag));
        end else begin
          d3 = cdmc_pkg::SEG_BLANK;
        end
      end
      cdmc_pkg::MODE_SET_H: begin
        d3 = it.lit ? h1 : cdmc_pkg::SEG_DP;
        d2 = it.lit ? h0 : cdmc_pkg::SEG_DP;
        d1 = m1;
        d0 = m0;
      end
      default: begin
        d3 = h1;
        d2 = h0;
        d1 = it.lit ? m1 : cdmc_pkg::SEG_DP;
        d0 = it.lit ? m0 : cdmc_pkg::SEG_DP;
      end
    endcase

    res.seg_digit3    = d3;
    res.seg_digit2    = d2;
    res.seg_digit1    = d1;
    res.seg_digit0    = d0;
    res.mode_now      = mode_nxt;
    res.time_write    = wr;
    res.write_hours   = wr ? show_h : '0;
    res.write_minutes = wr ? show_m : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= cdmc_pkg::MODE_CLOCK;
      cycle_start_r   <= '0;
      press_start_r   <= '0;
      press_seen_r    <= 1'b0;
      edit_hours_r    <= cdmc_pkg::EDIT_HOURS_RESET;
      edit_minutes_r  <= '0;
      held_temp_r     <= '0;
      snapshot_done_r <= 1'b0;
    end else if (adv) begin
      mode_r          <= mode_nxt;
      cycle_start_r   <= cycle_start_nxt;
      press_start_r   <= press_start_nxt;
      press_seen_r    <= press_seen_nxt;
      edit_hours_r    <= edit_hours_nxt;
      edit_minutes_r  <= edit_minutes_nxt;
      held_temp_r     <= held_temp_nxt;
      snapshot_done_r <= snapshot_done_nxt;
    end
  end

endmodule

// ----- sv/cdmc_out_stage.sv -----
// Result register driving the display result channel.
`timescale 1ns / 1ps

module cdmc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  cdmc_pkg::result_t  res,
  output logic               can_take,
  cdmc_out_if.source         out_ch
);

  logic               valid_r;
  logic               valid_nxt;
  cdmc_pkg::result_t  res_r;

  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.seg_digit3    = res_r.seg_digit3;
  assign out_ch.seg_digit2    = res_r.seg_digit2;
  assign out_ch.seg_digit1    = res_r.seg_digit1;
  assign out_ch.seg_digit0    = res_r.seg_digit0;
  assign out_ch.mode_now      = res_r.mode_now;
  assign out_ch.time_write    = res_r.time_write;
  assign out_ch.write_hours   = res_r.write_hours;
  assign out_ch.write_minutes = res_r.write_minutes;

endmodule

// ----- sv/clock_display_mode_controller.sv -----
// Top level of the clock display mode controller.
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     tick, button, clock time, colon, temperature
//   out_ch    out   valid/ready     four segment bytes, mode, time write
//   cfg_*     in    cfg_we          register index and 16-bit data
//
// One sample per clock unless out_ch stalls: input register, one pass of step
// logic, result register. Result is valid once loaded into the result register.
// Blink phase is computed from the tick as the sample enters the input register.
// A stalled result holds the input register; a full input register takes a new
// sample in the cycle it hands its own to the result register.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
`include "clock_display_mode_controller_assert.svh"

module clock_display_mode_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  cdmc_in_if.sink                          in_ch,
  cdmc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cdmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdmc_pkg::CFG_W-1:0]       cfg_wdata
);

  cdmc_pkg::cfg_t     cfg;
  cdmc_pkg::item_t    s1_item;
  cdmc_pkg::result_t  res;
  logic               s1_valid;
  logic               can_take;
  logic               adv;

  assign adv = s1_valid && can_take;

  cdmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdmc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cdmc_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .it    (s1_item),
    .cfg   (cfg),
    .res   (res)
  );

  cdmc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  `CDMC_ASSERT_IMP(a_commit_normal, out_ch.valid && out_ch.time_write,
                   out_ch.mode_now == cdmc_pkg::MODE_CLOCK)
  `CDMC_ASSERT_IMP(a_no_write_zero, out_ch.valid && !out_ch.time_write,
                   out_ch.write_hours == 5'd0 && out_ch.write_minutes == 6'd0)
  `CDMC_ASSERT_IMP(a_set_colon,
                   out_ch.valid && (out_ch.mode_now == cdmc_pkg::MODE_SET_H ||
                                    out_ch.mode_now == cdmc_pkg::MODE_SET_M),
                   out_ch.seg_digit3[7] && out_ch.seg_digit0[7])
  `CDMC_ASSERT_NEXT(a_adv_fills_out, adv, out_ch.valid)

endmodule
